FILE: hw/rtl/stki_pkg.sv
`timescale 1ns / 1ps
package stki_pkg;

  // Default table and vector depths
  localparam int STKI_MAX_ENTRIES = 64;
  localparam int STKI_MAX_COORDS  = 16;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int ENTRIES_W = 7;
  localparam int COORDS_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // Reset values of the configuration registers
  localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 7'd64;
  localparam logic [COORDS_W-1:0]  COORDS_RST  = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COORDS  = 2'd1;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_FULL_RD,
    S_FULL_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_SETUP,
    S_KSH,
    S_KSH_END,
    S_VSH,
    S_VSH_END,
    S_KWR,
    S_VWR,
    S_VWR_END,
    S_BEST_RD,
    S_BEST_LD,
    S_RD_KEY,
    S_RD_KEY_LD,
    S_RD_VEC,
    S_RD_VEC_LD,
    S_RES
  } state_t;

endpackage

FILE: hw/rtl/stki_if.sv
`timescale 1ns / 1ps
// Input item channel
interface stki_in_if;
  logic                              valid;
  logic                              ready;
  logic [stki_pkg::KIND_W-1:0]       kind;
  logic signed [stki_pkg::DATA_W-1:0] key;
  logic signed [stki_pkg::DATA_W-1:0] coord;
  logic                              coord_last;
  modport source (output valid, kind, key, coord, coord_last, input ready);
  modport sink   (input valid, kind, key, coord, coord_last, output ready);
endinterface

// Result channel
interface stki_out_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic [stki_pkg::SLOT_W-1:0]        slot;
  logic signed [stki_pkg::DATA_W-1:0] best_key;
  logic signed [stki_pkg::DATA_W-1:0] best_coord;
  logic                               out_last;
  modport source (output valid, accepted, slot, best_key, best_coord, out_last, input ready);
  modport sink   (input valid, accepted, slot, best_key, best_coord, out_last, output ready);
endinterface

// Configuration write channel
interface stki_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stki_pkg::CFG_IDX_W-1:0] index;
  logic [stki_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/stki_store.sv
`timescale 1ns / 1ps
module stki_store #(
  parameter int MAX_ENTRIES = stki_pkg::STKI_MAX_ENTRIES,
  parameter int MAX_COORDS  = stki_pkg::STKI_MAX_COORDS,
  localparam int AW  = $clog2(MAX_ENTRIES),
  localparam int VAW = $clog2(MAX_ENTRIES * MAX_COORDS)
) (
  input  logic                        clk,
  input  logic                        k_we,
  input  logic [AW-1:0]               k_waddr,
  input  logic [stki_pkg::DATA_W-1:0] k_wdata,
  input  logic                        k_re,
  input  logic [AW-1:0]               k_raddr,
  output logic [stki_pkg::DATA_W-1:0] k_rdata,
  input  logic                        v_we,
  input  logic [VAW-1:0]              v_waddr,
  input  logic [stki_pkg::DATA_W-1:0] v_wdata,
  input  logic                        v_re,
  input  logic [VAW-1:0]              v_raddr,
  output logic [stki_pkg::DATA_W-1:0] v_rdata
);
  import stki_pkg::*;

  logic [DATA_W-1:0] key_mem [MAX_ENTRIES];
  logic [DATA_W-1:0] vec_mem [MAX_ENTRIES * MAX_COORDS];

  // Key store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (k_we) begin
      key_mem[k_waddr] <= k_wdata;
    end
    if (k_re) begin
      k_rdata <= key_mem[k_raddr];
    end
  end

  // Vector store, row-major, MAX_COORDS words per entry
  always_ff @(posedge clk) begin
    if (v_we) begin
      vec_mem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      v_rdata <= vec_mem[v_raddr];
    end
  end

endmodule

FILE: hw/rtl/stki_ctrl.sv
`timescale 1ns / 1ps
module stki_ctrl #(
  parameter int MAX_ENTRIES = stki_pkg::STKI_MAX_ENTRIES,
  parameter int MAX_COORDS  = stki_pkg::STKI_MAX_COORDS,
  localparam int AW  = $clog2(MAX_ENTRIES),
  localparam int EW  = $clog2(MAX_ENTRIES + 1),
  localparam int CAW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1,
  localparam int CW  = $clog2(MAX_COORDS + 1),
  localparam int VAW = $clog2(MAX_ENTRIES * MAX_COORDS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // effective configuration
  input  logic [EW-1:0]                      cap,
  input  logic [CW-1:0]                      nc,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stki_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [stki_pkg::DATA_W-1:0] in_key,
  input  logic signed [stki_pkg::DATA_W-1:0] in_coord,
  input  logic                               in_coord_last,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [stki_pkg::SLOT_W-1:0]        out_slot,
  output logic signed [stki_pkg::DATA_W-1:0] out_best_key,
  output logic signed [stki_pkg::DATA_W-1:0] out_best_coord,
  output logic                               out_out_last,
  // table memories
  output logic                               k_we,
  output logic [AW-1:0]                      k_waddr,
  output logic [stki_pkg::DATA_W-1:0]        k_wdata,
  output logic                               k_re,
  output logic [AW-1:0]                      k_raddr,
  input  logic [stki_pkg::DATA_W-1:0]        k_rdata,
  output logic                               v_we,
  output logic [VAW-1:0]                     v_waddr,
  output logic [stki_pkg::DATA_W-1:0]        v_wdata,
  output logic                               v_re,
  output logic [VAW-1:0]                     v_raddr,
  input  logic [stki_pkg::DATA_W-1:0]        v_rdata
);
  import stki_pkg::*;

  state_t state_r, state_nxt;

  // control state
  logic [EW-1:0]  filled_r, filled_nxt;
  logic [CW-1:0]  ci_r, ci_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           wp_r, wp_nxt;
  logic           rdo_r, rdo_nxt;

  // working registers
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           inc_r, inc_nxt;
  logic           acc_r, acc_nxt;
  logic [EW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]  mid_r, mid_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  dst_last_r, dst_last_nxt;
  logic [AW-1:0]  ksrc_r, ksrc_nxt, ka_r, ka_nxt;
  logic [VAW-1:0] vsrc_r, vsrc_nxt, vend_r, vend_nxt, va_r, va_nxt;
  logic [CAW-1:0] j_r, j_nxt, wj_r, wj_nxt;
  logic           wz_r, wz_nxt;
  logic [DATA_W-1:0] bk_r, bk_nxt;

  // result register
  logic                     o_acc_r, o_acc_nxt;
  logic [SLOT_W-1:0]        o_slot_r, o_slot_nxt;
  logic signed [DATA_W-1:0] o_bk_r, o_bk_nxt;
  logic signed [DATA_W-1:0] o_bc_r, o_bc_nxt;
  logic                     o_last_r, o_last_nxt;

  // candidate buffer
  logic [DATA_W-1:0] cand_mem [MAX_COORDS];
  logic [DATA_W-1:0] c_rdata;
  logic              c_we, c_re;
  logic [CAW-1:0]    c_raddr;

  // shared decisions
  logic          in_fire, is_coord, ci_room, room, srch_done, rd_less, cand_less;
  logic [EW-1:0] filled_c;
  logic [EW:0]   mid_sum;
  logic          rd_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_coord  = (in_kind == KIND_LOAD) || (in_kind == KIND_OFFER);
  assign ci_room   = (ci_r < nc);
  assign filled_c  = (filled_r > cap) ? cap : filled_r;
  assign room      = (filled_c < cap);
  assign srch_done = (lo_r >= hi_r);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign rd_less   = ($signed(k_rdata) < key_r);
  assign cand_less = (key_r < $signed(k_rdata));
  assign rd_last   = (CW'(j_r) == nc - CW'(1));

  // candidate buffer write and registered read
  assign c_we = in_fire && is_coord && ci_room;
  always_ff @(posedge clk) begin
    if (c_we) begin
      cand_mem[ci_r[CAW-1:0]] <= in_coord;
    end
    if (c_re) begin
      c_rdata <= cand_mem[c_raddr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_coord && in_coord_last) begin
            if (room) begin
              state_nxt = S_SRCH_RD;
            end else if (in_kind == KIND_OFFER) begin
              state_nxt = S_FULL_RD;
            end else begin
              state_nxt = S_BEST_RD;
            end
          end else if (in_kind == KIND_READ) begin
            state_nxt = (filled_c == '0) ? S_RES : S_RD_KEY;
          end
        end
      end
      S_FULL_RD:     state_nxt = S_FULL_CMP;
      S_FULL_CMP:    state_nxt = cand_less ? S_SRCH_RD : S_BEST_RD;
      S_SRCH_RD:     state_nxt = srch_done ? S_SHIFT_SETUP : S_SRCH_CMP;
      S_SRCH_CMP:    state_nxt = S_SRCH_RD;
      S_SHIFT_SETUP: state_nxt = (dst_last_r > pos_r) ? S_KSH : S_KWR;
      S_KSH:         state_nxt = (ksrc_r == pos_r) ? S_KSH_END : S_KSH;
      S_KSH_END:     state_nxt = S_VSH;
      S_VSH:         state_nxt = (vsrc_r == vend_r) ? S_VSH_END : S_VSH;
      S_VSH_END:     state_nxt = S_KWR;
      S_KWR:         state_nxt = S_VWR;
      S_VWR:         state_nxt = (j_r == CAW'(MAX_COORDS - 1)) ? S_VWR_END : S_VWR;
      S_VWR_END:     state_nxt = S_BEST_RD;
      S_BEST_RD:     state_nxt = S_BEST_LD;
      S_BEST_LD:     state_nxt = S_RES;
      S_RD_KEY:      state_nxt = S_RD_KEY_LD;
      S_RD_KEY_LD:   state_nxt = S_RD_VEC;
      S_RD_VEC:      state_nxt = S_RD_VEC_LD;
      S_RD_VEC_LD:   state_nxt = S_RES;
      S_RES: begin
        if (out_ready) begin
          state_nxt = (rdo_r && !o_last_r) ? S_RD_VEC : S_IDLE;
        end
      end
      default:       state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    filled_nxt    = filled_c;
    ci_nxt        = ci_r;
    out_valid_nxt = out_valid_r;
    wp_nxt        = wp_r;
    rdo_nxt       = rdo_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    inc_nxt       = inc_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    dst_last_nxt  = dst_last_r;
    ksrc_nxt      = ksrc_r;
    ka_nxt        = ka_r;
    vsrc_nxt      = vsrc_r;
    vend_nxt      = vend_r;
    va_nxt        = va_r;
    j_nxt         = j_r;
    wj_nxt        = wj_r;
    wz_nxt        = wz_r;
    bk_nxt        = bk_r;
    o_acc_nxt     = o_acc_r;
    o_slot_nxt    = o_slot_r;
    o_bk_nxt      = o_bk_r;
    o_bc_nxt      = o_bc_r;
    o_last_nxt    = o_last_r;
    k_we    = 1'b0;
    k_waddr = ka_r;
    k_wdata = k_rdata;
    k_re    = 1'b0;
    k_raddr = '0;
    v_we    = 1'b0;
    v_waddr = va_r;
    v_wdata = v_rdata;
    v_re    = 1'b0;
    v_raddr = '0;
    c_re    = 1'b0;
    c_raddr = j_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && is_coord) begin
          ci_nxt = ci_room ? ci_r + CW'(1) : ci_r;
          if (in_coord_last) begin
            ci_nxt       = '0;
            cnt_nxt      = ci_room ? ci_r + CW'(1) : ci_r;
            key_nxt      = in_key;
            acc_nxt      = 1'b0;
            inc_nxt      = room;
            lo_nxt       = '0;
            hi_nxt       = room ? filled_c : cap;
            dst_last_nxt = room ? AW'(filled_c) : AW'(cap - EW'(1));
          end
        end else if (in_fire && (in_kind == KIND_READ)) begin
          rdo_nxt = 1'b0;
          if (filled_c == '0) begin
            o_acc_nxt     = 1'b0;
            o_slot_nxt    = '0;
            o_bk_nxt      = '0;
            o_bc_nxt      = '0;
            o_last_nxt    = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            rdo_nxt = 1'b1;
          end
        end
      end
      // full table: compare with the worst entry
      S_FULL_RD: begin
        k_re    = 1'b1;
        k_raddr = AW'(cap - EW'(1));
      end
      // binary search, lower bound
      S_SRCH_RD: begin
        mid_nxt = AW'(mid_sum >> 1);
        k_re    = !srch_done;
        k_raddr = AW'(mid_sum >> 1);
        if (srch_done) begin
          pos_nxt = AW'(lo_r);
        end
      end
      S_SRCH_CMP: begin
        if (rd_less) begin
          lo_nxt = EW'(mid_r) + EW'(1);
        end else begin
          hi_nxt = EW'(mid_r);
        end
      end
      S_SHIFT_SETUP: begin
        ksrc_nxt = dst_last_r - AW'(1);
        vsrc_nxt = VAW'(dst_last_r) * VAW'(MAX_COORDS) - VAW'(1);
        vend_nxt = VAW'(pos_r) * VAW'(MAX_COORDS);
        wp_nxt   = 1'b0;
      end
      // keys move down one slot; each key is written in the cycle after it is read
      S_KSH: begin
        k_re     = 1'b1;
        k_raddr  = ksrc_r;
        k_we     = wp_r;
        ka_nxt   = ksrc_r + AW'(1);
        wp_nxt   = 1'b1;
        ksrc_nxt = ksrc_r - AW'(1);
      end
      S_KSH_END: begin
        k_we   = 1'b1;
        wp_nxt = 1'b0;
      end
      // vector words move down one row
      S_VSH: begin
        v_re     = 1'b1;
        v_raddr  = vsrc_r;
        v_we     = wp_r;
        va_nxt   = vsrc_r + VAW'(MAX_COORDS);
        wp_nxt   = 1'b1;
        vsrc_nxt = vsrc_r - VAW'(1);
      end
      S_VSH_END: begin
        v_we   = 1'b1;
        wp_nxt = 1'b0;
      end
      S_KWR: begin
        k_we    = 1'b1;
        k_waddr = pos_r;
        k_wdata = key_r;
        j_nxt   = '0;
        wp_nxt  = 1'b0;
      end
      // candidate copied into its row, unused words zero
      S_VWR: begin
        c_re    = 1'b1;
        v_we    = wp_r;
        v_waddr = vend_r + VAW'(wj_r);
        v_wdata = wz_r ? '0 : c_rdata;
        wj_nxt  = j_r;
        wz_nxt  = (CW'(j_r) >= cnt_r);
        wp_nxt  = 1'b1;
        j_nxt   = j_r + CAW'(1);
      end
      S_VWR_END: begin
        v_we    = 1'b1;
        v_waddr = vend_r + VAW'(wj_r);
        v_wdata = wz_r ? '0 : c_rdata;
        wp_nxt  = 1'b0;
        acc_nxt = 1'b1;
        if (inc_r) begin
          filled_nxt = filled_c + EW'(1);
        end
      end
      S_BEST_RD: begin
        k_re    = 1'b1;
        k_raddr = '0;
      end
      S_BEST_LD: begin
        o_acc_nxt     = acc_r;
        o_slot_nxt    = acc_r ? SLOT_W'(pos_r) : '0;
        o_bk_nxt      = k_rdata;
        o_bc_nxt      = '0;
        o_last_nxt    = 1'b1;
        out_valid_nxt = 1'b1;
        rdo_nxt       = 1'b0;
      end
      // readout of the best vector
      S_RD_KEY: begin
        k_re    = 1'b1;
        k_raddr = '0;
        j_nxt   = '0;
      end
      S_RD_KEY_LD: begin
        bk_nxt = k_rdata;
      end
      S_RD_VEC: begin
        v_re    = 1'b1;
        v_raddr = VAW'(j_r);
      end
      S_RD_VEC_LD: begin
        o_acc_nxt     = 1'b0;
        o_slot_nxt    = '0;
        o_bk_nxt      = bk_r;
        o_bc_nxt      = v_rdata;
        o_last_nxt    = rd_last;
        out_valid_nxt = 1'b1;
      end
      S_RES: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          j_nxt         = j_r + CAW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
      wp_r        <= 1'b0;
      rdo_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      ci_r        <= ci_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      rdo_r       <= rdo_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    cnt_r      <= cnt_nxt;
    inc_r      <= inc_nxt;
    acc_r      <= acc_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    pos_r      <= pos_nxt;
    dst_last_r <= dst_last_nxt;
    ksrc_r     <= ksrc_nxt;
    ka_r       <= ka_nxt;
    vsrc_r     <= vsrc_nxt;
    vend_r     <= vend_nxt;
    va_r       <= va_nxt;
    j_r        <= j_nxt;
    wj_r       <= wj_nxt;
    wz_r       <= wz_nxt;
    bk_r       <= bk_nxt;
    o_acc_r    <= o_acc_nxt;
    o_slot_r   <= o_slot_nxt;
    o_bk_r     <= o_bk_nxt;
    o_bc_r     <= o_bc_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = o_acc_r;
  assign out_slot       = o_slot_r;
  assign out_best_key   = o_bk_r;
  assign out_best_coord = o_bc_r;
  assign out_out_last   = o_last_r;

  // a pending result blocks new items
  a_res_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready)
    else $error("item taken while a result is pending");

  // fill level stays within the table
  a_filled_range: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= EW'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  // no read and write of the same key entry in one cycle
  a_key_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (k_we && k_re) |-> (k_waddr != k_raddr))
    else $error("key store read and write collide");

  // final result transfer returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && out_ready && o_last_r) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle");

  // coordinate counter stays within the buffer
  a_ci_range: assert property (@(posedge clk) disable iff (!rst_n)
    ci_r <= CW'(MAX_COORDS))
    else $error("coordinate index beyond buffer depth");

endmodule

FILE: hw/rtl/sorted_top_k_insert.sv
`timescale 1ns / 1ps
// Sorted top-K vector table.
// in_ch carries one coordinate per transfer (kind load or offer); the transfer
// with coord_last set also carries the key and places the vector by binary
// search, with worse entries moving down one slot. A read transfer streams out
// the best vector, one coordinate per result transfer on out_ch.
// cfg_ch writes entries_in_use (index 0) and coords_in_use (index 1); it is
// always ready; the user must write it only while the block is idle (unchecked).
// A plain coordinate is written to the candidate buffer. A finishing coordinate
// runs the binary search, moves the keys and then the vector words of worse
// entries down, writes the key and the vector row, and reads the best key for
// its result transfer; a load into a full table, or an offer no better than the
// worst entry, places nothing. The single read and write port of the vector
// store moves one word a cycle. A readout reads the best key, then each word.
// One item is worked on at a time; in_ch.ready is high only when idle.
// Reset clears the fill level and coordinate counter and sets the registers
// to 64 and 16; the table memories are not cleared.
// While out_ch stalls, the result is held and no input is taken.
module sorted_top_k_insert #(
  parameter int MAX_ENTRIES = stki_pkg::STKI_MAX_ENTRIES,
  parameter int MAX_COORDS  = stki_pkg::STKI_MAX_COORDS
) (
  input  logic       clk,
  input  logic       rst_n,
  stki_in_if.sink    in_ch,
  stki_out_if.source out_ch,
  stki_cfg_if.sink   cfg_ch
);
  import stki_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = $clog2(MAX_COORDS + 1);
  localparam int VAW = $clog2(MAX_ENTRIES * MAX_COORDS);

  logic [ENTRIES_W-1:0] entries_r, entries_nxt;
  logic [COORDS_W-1:0]  coords_r, coords_nxt;
  logic [EW-1:0]        cap;
  logic [CW-1:0]        nc;

  logic              k_we, k_re, v_we, v_re;
  logic [AW-1:0]     k_waddr, k_raddr;
  logic [VAW-1:0]    v_waddr, v_raddr;
  logic [DATA_W-1:0] k_wdata, k_rdata, v_wdata, v_rdata;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_comb begin
    entries_nxt = entries_r;
    coords_nxt  = coords_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ENTRIES: entries_nxt = cfg_ch.data[ENTRIES_W-1:0];
        CFG_COORDS:  coords_nxt  = cfg_ch.data[COORDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RST;
      coords_r  <= COORDS_RST;
    end else begin
      entries_r <= entries_nxt;
      coords_r  <= coords_nxt;
    end
  end

  // effective sizes, clamped into range
  always_comb begin
    if (entries_r == '0) begin
      cap = EW'(1);
    end else if (32'(entries_r) > 32'(MAX_ENTRIES)) begin
      cap = EW'(MAX_ENTRIES);
    end else begin
      cap = EW'(entries_r);
    end
    if (coords_r == '0) begin
      nc = CW'(1);
    end else if (32'(coords_r) > 32'(MAX_COORDS)) begin
      nc = CW'(MAX_COORDS);
    end else begin
      nc = CW'(coords_r);
    end
  end

  stki_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_COORDS (MAX_COORDS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cap           (cap),
    .nc            (nc),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_kind       (in_ch.kind),
    .in_key        (in_ch.key),
    .in_coord      (in_ch.coord),
    .in_coord_last (in_ch.coord_last),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_accepted  (out_ch.accepted),
    .out_slot      (out_ch.slot),
    .out_best_key  (out_ch.best_key),
    .out_best_coord(out_ch.best_coord),
    .out_out_last  (out_ch.out_last),
    .k_we          (k_we),
    .k_waddr       (k_waddr),
    .k_wdata       (k_wdata),
    .k_re          (k_re),
    .k_raddr       (k_raddr),
    .k_rdata       (k_rdata),
    .v_we          (v_we),
    .v_waddr       (v_waddr),
    .v_wdata       (v_wdata),
    .v_re          (v_re),
    .v_raddr       (v_raddr),
    .v_rdata       (v_rdata)
  );

  stki_store #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_COORDS (MAX_COORDS)
  ) u_store (
    .clk    (clk),
    .k_we   (k_we),
    .k_waddr(k_waddr),
    .k_wdata(k_wdata),
    .k_re   (k_re),
    .k_raddr(k_raddr),
    .k_rdata(k_rdata),
    .v_we   (v_we),
    .v_waddr(v_waddr),
    .v_wdata(v_wdata),
    .v_re   (v_re),
    .v_raddr(v_raddr),
    .v_rdata(v_rdata)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import stki_pkg::*;

  // Code that the block ignores
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       key;
    logic [31:0]       coord;
    logic              last;
  } coord_item_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       best_key;
    logic [31:0]       best_coord;
    logic              last;
  } table_result_t;

  logic clk;
  logic rst_n;

  stki_in_if  in_ch ();
  stki_out_if out_ch ();
  stki_cfg_if cfg_ch ();

  sorted_top_k_insert i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the table
  logic [31:0]          key_mem [STKI_MAX_ENTRIES];
  logic [31:0]          vec_mem [STKI_MAX_ENTRIES*STKI_MAX_COORDS];
  logic [31:0]          cand_buf [STKI_MAX_COORDS];
  int                   cand_cnt;
  int                   fill_cnt;
  logic [ENTRIES_W-1:0] entries_reg;
  logic [COORDS_W-1:0]  coords_reg;

  coord_item_t   pending_items[$];
  table_result_t expected_results[$];
  int            err_cnt;
  int            items_sent;
  int            results_seen;
  int            inserts_seen;
  int            send_idle_pct;
  int            recv_stall_pct;
  logic          in_took;

  function automatic int eff_entries();
    if (entries_reg == 0) return 1;
    if (entries_reg > STKI_MAX_ENTRIES) return STKI_MAX_ENTRIES;
    return entries_reg;
  endfunction

  function automatic int eff_coords();
    if (coords_reg == 0) return 1;
    if (coords_reg > STKI_MAX_COORDS) return STKI_MAX_COORDS;
    return coords_reg;
  endfunction

  // Lower-bound search, shift worse entries down, write the candidate
  function automatic int insert_candidate(int n, int cap, logic [31:0] k);
    int lo, hi, mid, tail;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if ($signed(key_mem[mid]) < $signed(k)) lo = mid + 1;
      else hi = mid;
    end
    tail = (n < cap) ? n : cap - 1;
    for (int i = tail; i > lo; i--) begin
      key_mem[i] = key_mem[i-1];
      for (int j = 0; j < STKI_MAX_COORDS; j++)
        vec_mem[i*STKI_MAX_COORDS+j] = vec_mem[(i-1)*STKI_MAX_COORDS+j];
    end
    key_mem[lo] = k;
    for (int j = 0; j < STKI_MAX_COORDS; j++)
      vec_mem[lo*STKI_MAX_COORDS+j] = (j < cand_cnt) ? cand_buf[j] : 32'd0;
    return lo;
  endfunction

  // Work out the results of one accepted item
  function automatic void table_step(coord_item_t it);
    int            cap, nc, pos;
    table_result_t r;
    cap = eff_entries();
    nc  = eff_coords();
    if (it.kind == KIND_READ) begin
      if (fill_cnt == 0) begin
        expected_results.push_back('{1'b0, '0, 32'd0, 32'd0, 1'b1});
      end else begin
        for (int j = 0; j < nc; j++)
          expected_results.push_back('{1'b0, '0, key_mem[0], vec_mem[j], j == nc - 1});
      end
    end else if (it.kind == KIND_LOAD || it.kind == KIND_OFFER) begin
      if (cand_cnt < nc) begin
        cand_buf[cand_cnt] = it.coord;
        cand_cnt++;
      end
      if (it.last) begin
        r = '0;
        if (fill_cnt > cap) fill_cnt = cap;
        if (fill_cnt < cap) begin
          pos = insert_candidate(fill_cnt, cap, it.key);
          fill_cnt++;
          r.accepted = 1'b1;
          r.slot = pos[SLOT_W-1:0];
        end else if (it.kind == KIND_OFFER && $signed(it.key) < $signed(key_mem[cap-1])) begin
          pos = insert_candidate(cap, cap, it.key);
          r.accepted = 1'b1;
          r.slot = pos[SLOT_W-1:0];
        end
        cand_cnt = 0;
        r.best_key = (fill_cnt > 0) ? key_mem[0] : 32'd0;
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    err_cnt++;
  endtask

  // Monitor: check results, then predict from the accepted transfer
  always @(posedge clk) begin
    table_result_t want;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report("result with nothing expected", out_ch.best_key, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.accepted && out_ch.out_last && out_ch.best_coord == 0) inserts_seen++;
          if (out_ch.accepted !== want.accepted)
            report("accepted", out_ch.accepted, want.accepted);
          if (out_ch.slot !== want.slot) report("slot", out_ch.slot, want.slot);
          if (out_ch.best_key !== want.best_key)
            report("best_key", out_ch.best_key, want.best_key);
          if (out_ch.best_coord !== want.best_coord)
            report("best_coord", out_ch.best_coord, want.best_coord);
          if (out_ch.out_last !== want.last) report("out_last", out_ch.out_last, want.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        items_sent++;
        table_step('{in_ch.kind, in_ch.key, in_ch.coord, in_ch.coord_last});
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ENTRIES) begin
          entries_reg = cfg_ch.data[ENTRIES_W-1:0];
          if (fill_cnt > eff_entries()) fill_cnt = eff_entries();
        end else if (cfg_ch.index == CFG_COORDS) begin
          coords_reg = cfg_ch.data[COORDS_W-1:0];
        end
      end
    end
  end

  // Driver: one item per transfer, random gaps
  always @(negedge clk) begin
    coord_item_t it;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= it.kind;
        in_ch.key        <= it.key;
        in_ch.coord      <= it.coord;
        in_ch.coord_last <= it.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return {16'(int'($urandom_range(0, 6)) - 3), 16'($urandom)};
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] KIND_KIND(int i);
    return i[0] ? KIND_OFFER : KIND_LOAD;
  endfunction

  // Queue one vector of len coordinates; some vectors mix kinds
  function automatic void add_vector(logic [KIND_W-1:0] k, int len, logic [31:0] key);
    logic mixed;
    mixed = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      pending_items.push_back('{
        (mixed && i != len - 1) ? KIND_KIND(i) : k,
        (i == len - 1) ? key : $urandom,
        (i == 0 && $urandom_range(0, 5) == 0) ? 32'h8000_0000 : $urandom,
        i == len - 1});
      if ($urandom_range(0, 19) == 0)
        pending_items.push_back('{KIND_READ, $urandom, $urandom, 1'($urandom)});
    end
  endfunction

  // Random traffic: mostly full vectors, some short or long, reads and noise
  function automatic void add_random(int count);
    int nc, len, r;
    nc = eff_coords();
    while (count > 0) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        pending_items.push_back('{KIND_READ, $urandom, $urandom, 1'($urandom)});
        count--;
      end else if (r < 15) begin
        pending_items.push_back('{KIND_NONE, $urandom, $urandom, 1'($urandom)});
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, nc + 2) : nc;
        add_vector($urandom_range(0, 2) == 0 ? KIND_LOAD : KIND_OFFER, len, rand_key());
        count -= len;
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DAT_W-1:0];
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Phase settings: entries, coords
  int phase_entries[8] = '{4, 1, 127, 2, 0, 64, 8, 3};
  int phase_coords [8] = '{3, 1, 31, 16, 0, 2, 5, 4};

  initial begin
    err_cnt        = 0;
    items_sent     = 0;
    results_seen   = 0;
    inserts_seen   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cand_cnt       = 0;
    fill_cnt       = 0;
    entries_reg    = ENTRIES_RST;
    coords_reg     = COORDS_RST;
    in_took        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.key        = '0;
    in_ch.coord      = '0;
    in_ch.coord_last = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_ENTRIES;
    cfg_ch.data      = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty read, extreme keys, short vector, equal keys, mixed kinds
    pending_items.push_back('{KIND_READ, 32'h0, 32'h0, 1'b0});
    pending_items.push_back('{KIND_NONE, 32'hffff_ffff, 32'hffff_ffff, 1'b1});
    pending_items.push_back('{KIND_LOAD, 32'h0, 32'h7fff_ffff, 1'b0});
    pending_items.push_back('{KIND_LOAD, 32'h7fff_ffff, 32'h8000_0000, 1'b1});
    pending_items.push_back('{KIND_LOAD, 32'h0, 32'hffff_ffff, 1'b0});
    pending_items.push_back('{KIND_READ, 32'h0, 32'h0, 1'b0});
    pending_items.push_back('{KIND_OFFER, 32'h8000_0000, 32'h1234_5678, 1'b1});
    pending_items.push_back('{KIND_READ, 32'hffff_ffff, 32'hffff_ffff, 1'b1});
    pending_items.push_back('{KIND_OFFER, 32'h0, 32'h0001_0000, 1'b0});
    pending_items.push_back('{KIND_LOAD, 32'h0, 32'hffff_0000, 1'b1});
    pending_items.push_back('{KIND_OFFER, 32'h0, 32'h0000_0001, 1'b1});
    pending_items.push_back('{KIND_LOAD, 32'h7fff_ffff, 32'h5, 1'b1});
    pending_items.push_back('{KIND_READ, 32'h0, 32'h0, 1'b0});
    wait_idle();

    // Random phases, each with its own setting and idling pattern
    for (int p = 0; p < 8; p++) begin
      cfg_write(CFG_ENTRIES, phase_entries[p]);
      cfg_write(CFG_COORDS, phase_coords[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      add_random(p == 2 ? 20 : 40);
      if (p == 3) begin
        // sender holds back until every result is in
        wait_idle();
        add_random(20);
      end
      wait_idle();
    end

    $display("Covered %0d input transfers and %0d result transfers (%0d insertions)",
             items_sent, results_seen, inserts_seen);
    $display("over 9 table settings, reads, ignored kinds and four idling patterns");
    if (err_cnt == 0) begin
      $display("sorted_top_k_insert: match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("sorted_top_k_insert: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("sorted_top_k_insert: mismatch");
    $finish;
  end

endmodule
